// ===== src/hsi_pkg.sv =====
// shared types, constants and the hue ratio table for the hsi to rgb converter
// no dependencies; used by every module of the block except hsi_fifo
package hsi_pkg;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 4;

    localparam int ANGLE_COUNT = 120;
    localparam int ANGLE_W     = 7;
    localparam int HUE_W       = 9;
    localparam int SAT_W       = 9;
    localparam int INT_W       = 9;
    localparam int RATIO_W     = 17;
    localparam int CHAN_W      = 8;

    localparam logic [HUE_W-1:0] HUE_WRAP     = 9'd360;
    localparam logic [HUE_W-1:0] SECTOR_SPAN  = 9'd120;
    localparam logic [HUE_W-1:0] SECTOR_SPAN2 = 9'd240;

    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] RAD_PER_DEG_Q60 = PI_Q60 / 64'd180;

    typedef enum logic [1:0] {
        SECTOR_RG = 2'd0,
        SECTOR_GB = 2'd1,
        SECTOR_BR = 2'd2
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [SAT_W-1:0] saturation;
        logic [INT_W-1:0] intensity;
    } hsi_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_color_t;

    typedef struct packed {
        sector_t                     sector;
        logic [SAT_W-1:0]            saturation;
        logic [INT_W-1:0]            intensity;
        logic signed [RATIO_W-1:0]   ratio;
    } hsi_work_t;

    typedef struct packed {
        logic take;
        logic push;
    } hsi_back_ctl_t;

    typedef logic signed [RATIO_W-1:0] ratio_tab_t [ANGLE_COUNT];

    // elaboration-time helpers for the ratio table
    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // unsigned quotient by shift and subtract
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic signed [63:0] cos_q60(int unsigned deg);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        den;
        logic signed [63:0] sum;
        x    = 64'(deg) * RAD_PER_DEG_Q60;
        x2   = mul_q60(x, x);
        term = ONE_Q60;
        sum  = $signed(ONE_Q60);
        for (int k = 1; k <= 40; k++)
        begin
            den  = 64'((2 * k - 1) * (2 * k));
            term = udiv64(mul_q60(term, x2), den);
            if ((k % 2) == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    function automatic ratio_tab_t build_ratio_tab();
        ratio_tab_t         tab;
        logic signed [63:0] ca;
        logic signed [63:0] cb;
        logic [63:0]        ma;
        logic [63:0]        mb;
        logic [63:0]        q;
        logic               neg;
        for (int unsigned a = 0; a < ANGLE_COUNT; a++)
        begin
            ca  = cos_q60(a);
            cb  = cos_q60((a <= 60) ? (60 - a) : (a - 60));
            neg = ca[63];
            ma  = (neg ? 64'(-ca) : 64'(ca)) >> 20;
            mb  = 64'(cb) >> 20;
            q   = udiv64(ma * 64'd32768 + mb, 64'd2 * mb);
            tab[a] = neg ? -$signed(q[RATIO_W-1:0]) : $signed(q[RATIO_W-1:0]);
        end
        return tab;
    endfunction

    localparam ratio_tab_t RATIO_TAB = build_ratio_tab();

endpackage

// ===== src/hsi_fifo.sv =====
// small first-in first-out queue with registered storage and a fill count
// depends on nothing; used for the work queue and the result queue
module hsi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/hsi_front.sv =====
// front end: hue wrap, sector split and ratio table lookup per accepted pixel
// depends on hsi_pkg
module hsi_front (
    input  logic                push,
    input  logic                full,
    input  hsi_pkg::hsi_pixel_t pixel,
    output logic                work_push,
    output hsi_pkg::hsi_work_t  work
);

    logic [hsi_pkg::HUE_W-1:0]   hue_wrapped;
    logic [hsi_pkg::HUE_W-1:0]   hue_offset;
    logic [hsi_pkg::ANGLE_W-1:0] angle;
    hsi_pkg::sector_t            sector;

    assign work_push = push && !full;

    always_comb
    begin
        hue_wrapped = (pixel.hue_deg >= hsi_pkg::HUE_WRAP)
                    ? pixel.hue_deg - hsi_pkg::HUE_WRAP : pixel.hue_deg;
        if (hue_wrapped >= hsi_pkg::SECTOR_SPAN2)
        begin
            sector     = hsi_pkg::SECTOR_BR;
            hue_offset = hue_wrapped - hsi_pkg::SECTOR_SPAN2;
        end
        else if (hue_wrapped >= hsi_pkg::SECTOR_SPAN)
        begin
            sector     = hsi_pkg::SECTOR_GB;
            hue_offset = hue_wrapped - hsi_pkg::SECTOR_SPAN;
        end
        else
        begin
            sector     = hsi_pkg::SECTOR_RG;
            hue_offset = hue_wrapped;
        end
        angle = hue_offset[hsi_pkg::ANGLE_W-1:0];

        work.sector     = sector;
        work.saturation = pixel.saturation;
        work.intensity  = pixel.intensity;
        work.ratio      = hsi_pkg::RATIO_TAB[angle];
    end

endmodule

// ===== src/hsi_back.sv =====
// back end: two-stage multiply pipeline and channel scaling into the result queue
// depends on hsi_pkg; issues only while the result queue has room for it
module hsi_back #(
    parameter int OUT_DEPTH = hsi_pkg::OUT_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           work_empty,
    input  hsi_pkg::hsi_work_t             work,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output hsi_pkg::hsi_back_ctl_t         ctl,
    output hsi_pkg::rgb_color_t            color
);

    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam int PW = 25;
    localparam int VW = 22;

    // stage one
    logic                         v1_reg;
    logic                         v1_next;
    hsi_pkg::sector_t             sector1_reg;
    logic [hsi_pkg::SAT_W-1:0]    sat1_reg;
    logic [hsi_pkg::INT_W-1:0]    int1_reg;
    logic signed [PW-1:0]         prod1_reg;
    logic signed [PW-1:0]         prod1_next;
    logic signed [26:0]           prod_full;

    // stage two
    logic                         v2_reg;
    logic                         v2_next;
    hsi_pkg::sector_t             sector2_reg;
    logic signed [VW-1:0]         hi2_reg;
    logic signed [VW-1:0]         lo2_reg;
    logic signed [VW-1:0]         mid2_reg;
    logic signed [VW-1:0]         hi2_next;
    logic signed [VW-1:0]         lo2_next;
    logic signed [VW-1:0]         mid2_next;

    logic signed [10:0]           shr;
    logic signed [11:0]           hi_f;
    logic signed [11:0]           lo_f;
    logic signed [11:0]           mid_f;
    logic signed [11:0]           sat_s;
    logic signed [11:0]           shr_s;
    logic signed [9:0]            int_s;
    logic [CW+1:0]                occupancy;
    logic                         take;

    logic [hsi_pkg::CHAN_W-1:0]   ch_hi;
    logic [hsi_pkg::CHAN_W-1:0]   ch_lo;
    logic [hsi_pkg::CHAN_W-1:0]   ch_mid;

    function automatic logic [hsi_pkg::CHAN_W-1:0] to_channel(logic signed [VW-1:0] v);
        logic [23:0] scaled;
        logic [23:0] v16;
        v16    = {8'd0, v[15:0]};
        scaled = {v[15:0], 8'd0} - v16;
        if (v <= 0)
        begin
            return '0;
        end
        else if (v >= VW'(65536))
        begin
            return '1;
        end
        else
        begin
            return scaled[23:16];
        end
    endfunction

    // credit check against queue fill plus items in flight
    assign occupancy = (CW+2)'(out_count) + (CW+2)'(v1_reg) + (CW+2)'(v2_reg);
    assign take      = !work_empty && (occupancy < (CW+2)'(OUT_DEPTH));

    assign prod_full  = $signed({1'b0, work.saturation}) * work.ratio;
    assign prod1_next = prod_full[PW-1:0];
    assign v1_next    = take;

    assign shr   = prod1_reg[PW-1:14];
    assign sat_s = $signed({3'b000, sat1_reg});
    assign shr_s = 12'(shr);
    assign int_s = $signed({1'b0, int1_reg});
    assign hi_f  = 12'sd256 + shr_s;
    assign lo_f  = 12'sd256 - sat_s;
    assign mid_f = 12'sd256 + sat_s - shr_s;

    assign hi2_next  = int_s * hi_f;
    assign lo2_next  = int_s * lo_f;
    assign mid2_next = int_s * mid_f;
    assign v2_next   = v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sector1_reg <= work.sector;
            sat1_reg    <= work.saturation;
            int1_reg    <= work.intensity;
            prod1_reg   <= prod1_next;
        end
        if (v1_reg)
        begin
            sector2_reg <= sector1_reg;
            hi2_reg     <= hi2_next;
            lo2_reg     <= lo2_next;
            mid2_reg    <= mid2_next;
        end
    end

    assign ch_hi  = to_channel(hi2_reg);
    assign ch_lo  = to_channel(lo2_reg);
    assign ch_mid = to_channel(mid2_reg);

    always_comb
    begin
        case (sector2_reg)
            hsi_pkg::SECTOR_RG:
            begin
                color.red   = ch_hi;
                color.green = ch_mid;
                color.blue  = ch_lo;
            end
            hsi_pkg::SECTOR_GB:
            begin
                color.red   = ch_lo;
                color.green = ch_hi;
                color.blue  = ch_mid;
            end
            default:
            begin
                color.red   = ch_mid;
                color.green = ch_lo;
                color.blue  = ch_hi;
            end
        endcase
    end

    assign ctl.take = take;
    assign ctl.push = v2_reg;

endmodule

// ===== src/hsi_to_rgb_converter_core.sv =====
// top level of the hsi to rgb converter: front end, work queue, back end, result queue
// depends on hsi_pkg, hsi_fifo, hsi_front and hsi_back
//
// Usage
// - input channel: a pixel (hue_deg, saturation, intensity) is transferred on a rising
//   edge with push high and full low; full only rises when the work queue is full
// - result channel: while empty is low the oldest colour (red, green, blue) is on
//   color; it is transferred on a rising edge with pop high
// - path: a transferred pixel goes from the work queue through the two back-end
//   multiply stages and the channel scaling into the result queue
// - throughput: one pixel per clock, set by the two back-end multiply stages; the
//   back end issues while result queue fill plus items in flight stays below
//   OUT_DEPTH, so OUT_DEPTH of 4 or more keeps the full rate
// - a stalled receiver fills the result queue, then the work queue, then full rises;
//   no result is lost or repeated
// - reset (rst_n low, asynchronous) empties both queues and the pipeline; full is
//   low and empty is high straight after reset, no clearing pass is needed
module hsi_to_rgb_converter_core #(
    parameter int MID_DEPTH = hsi_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = hsi_pkg::OUT_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  hsi_pkg::hsi_pixel_t pixel,
    output logic                empty,
    input  logic                pop,
    output hsi_pkg::rgb_color_t color
);

    localparam int WORK_W = $bits(hsi_pkg::hsi_work_t);
    localparam int RGB_W  = $bits(hsi_pkg::rgb_color_t);
    localparam int OCW    = $clog2(OUT_DEPTH + 1);
    localparam int MCW    = $clog2(MID_DEPTH + 1);

    logic                   work_push;
    hsi_pkg::hsi_work_t     work_in;
    hsi_pkg::hsi_work_t     work_out;
    logic [WORK_W-1:0]      work_rdata;
    logic                   mid_empty;
    logic [MCW-1:0]         mid_count;
    hsi_pkg::hsi_back_ctl_t ctl;
    hsi_pkg::rgb_color_t    back_color;
    logic [RGB_W-1:0]       out_rdata;
    logic                   out_full;
    logic [OCW-1:0]         out_count;

    hsi_front u_front (
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .work_push (work_push),
        .work      (work_in)
    );

    hsi_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (MID_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .wdata (work_in),
        .full  (full),
        .pop   (ctl.take),
        .rdata (work_rdata),
        .empty (mid_empty),
        .count (mid_count)
    );

    assign work_out = hsi_pkg::hsi_work_t'(work_rdata);

    hsi_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_empty (mid_empty),
        .work       (work_out),
        .out_count  (out_count),
        .ctl        (ctl),
        .color      (back_color)
    );

    hsi_fifo #(
        .WIDTH (RGB_W),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ctl.push),
        .wdata (back_color),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    assign color = hsi_pkg::rgb_color_t'(out_rdata);

    // checks
    a_take_needs_work: assert property (
        @(posedge clk) disable iff (!rst_n) ctl.take |-> !mid_empty
    ) else $error("back end took from an empty work queue");

    a_push_has_room: assert property (
        @(posedge clk) disable iff (!rst_n) ctl.push |-> !out_full
    ) else $error("result pushed into a full result queue");

    a_fixed_latency: assert property (
        @(posedge clk) disable iff (!rst_n) ctl.take |-> ##2 ctl.push
    ) else $error("issued item did not reach the result queue two cycles later");

    a_queue_counts: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_count <= OCW'(OUT_DEPTH)) && (mid_count <= MCW'(MID_DEPTH))
    ) else $error("queue fill count out of range");

endmodule

// ===== bench/tb_hsi_to_rgb_converter_core.sv =====
// self-checking bench for hsi_to_rgb_converter_core: pixels stream in, colours checked in order
// depends on hsi_pkg and hsi_to_rgb_converter_core; keeps its own hue ratio table and colour model
module tb_hsi_to_rgb_converter_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] Q60_ONE      = 64'h1000_0000_0000_0000;
    localparam logic [63:0] Q60_PI       = 64'h3243_F6A8_885A_308D;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          LONG_HOLD    = 80;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          MAX_REPORTS  = 10;

    typedef struct {
        hsi_pkg::hsi_pixel_t pix;
        int unsigned         gap;
    } pixel_offer_t;

    typedef struct {
        hsi_pkg::hsi_pixel_t pix;
        hsi_pkg::rgb_color_t colour;
    } colour_due_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                push      = 1'b0;
    logic                full;
    hsi_pkg::hsi_pixel_t pixel     = '0;
    logic                empty;
    logic                pop       = 1'b0;
    hsi_pkg::rgb_color_t color;

    logic        in_taken  = 1'b0;
    logic        out_taken = 1'b0;
    int unsigned gap_left  = 0;
    int unsigned hold_left = 0;
    int unsigned accepted  = 0;
    int unsigned received  = 0;
    int unsigned mismatches   = 0;
    int unsigned stall_cycles = 0;
    int unsigned total_items  = 0;

    int           hue_ratio [hsi_pkg::ANGLE_COUNT];
    pixel_offer_t pixel_backlog [$];
    colour_due_t  colour_due [$];

    hsi_to_rgb_converter_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pixel (pixel),
        .empty (empty),
        .pop   (pop),
        .color (color)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return wide[123:60];
    endfunction

    // cosine by power series in q60, angle in whole degrees
    function automatic longint cosine_q60(int unsigned deg);
        logic [63:0] x;
        logic [63:0] x_sq;
        logic [63:0] term;
        longint      acc;
        x    = 64'(deg) * (Q60_PI / 64'd180);
        x_sq = q60_mul(x, x);
        term = Q60_ONE;
        acc  = longint'(Q60_ONE);
        for (int k = 1; k <= 40; k++)
        begin
            term = q60_mul(term, x_sq) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    function automatic void fill_hue_ratio();
        longint      c_num;
        longint      c_den;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quot;
        for (int unsigned a = 0; a < hsi_pkg::ANGLE_COUNT; a++)
        begin
            c_num = cosine_q60(a);
            c_den = cosine_q60((a <= 60) ? (60 - a) : (a - 60));
            mag   = (c_num < 0) ? -c_num : c_num;
            num   = mag >> 20;
            den   = 64'(c_den) >> 20;
            quot  = (num * 64'd32768 + den) / (64'd2 * den);
            hue_ratio[a] = (c_num < 0) ? -int'(quot) : int'(quot);
        end
    endfunction

    function automatic logic [hsi_pkg::CHAN_W-1:0] scale_channel(longint v);
        longint t;
        if (v <= 0)
        begin
            return '0;
        end
        t = (v * 255) >>> 16;
        return (t > 255) ? 8'd255 : t[hsi_pkg::CHAN_W-1:0];
    endfunction

    function automatic hsi_pkg::rgb_color_t convert_pixel(hsi_pkg::hsi_pixel_t p);
        int unsigned         hue;
        int unsigned         angle;
        hsi_pkg::sector_t    sector;
        longint              sat;
        longint              inten;
        longint              lo;
        longint              hi;
        longint              mid;
        hsi_pkg::rgb_color_t c;
        hue    = p.hue_deg % hsi_pkg::HUE_WRAP;
        angle  = hue % hsi_pkg::SECTOR_SPAN;
        sector = hsi_pkg::sector_t'(hue / hsi_pkg::SECTOR_SPAN);
        sat    = p.saturation;
        inten  = p.intensity;
        lo     = inten * (256 - sat);
        hi     = inten * (256 + ((sat * longint'(hue_ratio[angle])) >>> 14));
        mid    = 768 * inten - lo - hi;
        case (sector)
            hsi_pkg::SECTOR_RG:
            begin
                c.red   = scale_channel(hi);
                c.green = scale_channel(mid);
                c.blue  = scale_channel(lo);
            end
            hsi_pkg::SECTOR_GB:
            begin
                c.red   = scale_channel(lo);
                c.green = scale_channel(hi);
                c.blue  = scale_channel(mid);
            end
            default:
            begin
                c.red   = scale_channel(mid);
                c.green = scale_channel(lo);
                c.blue  = scale_channel(hi);
            end
        endcase
        return c;
    endfunction

    function automatic logic [hsi_pkg::SAT_W-1:0] draw_level();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return 9'd256;
            2:       return 9'd511;
            3:       return 9'($urandom_range(0, 511));
            default: return 9'($urandom_range(0, 256));
        endcase
    endfunction

    function automatic int unsigned draw_receiver_wait();
        case ((received / 64) % 3)
            0:       return 0;
            1:       return $urandom_range(0, 17);
            default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        endcase
    endfunction

    task automatic queue_pixel(int unsigned hue, int unsigned sat, int unsigned inten,
                               int unsigned gap);
        pixel_offer_t offer;
        offer.pix.hue_deg    = hue[hsi_pkg::HUE_W-1:0];
        offer.pix.saturation = sat[hsi_pkg::SAT_W-1:0];
        offer.pix.intensity  = inten[hsi_pkg::INT_W-1:0];
        offer.gap            = gap;
        pixel_backlog.push_back(offer);
        total_items++;
    endtask

    task automatic report_mismatch(colour_due_t due, bit unexpected);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            if (unexpected)
            begin
                $display("unexpected colour %0d/%0d/%0d with nothing pending",
                         color.red, color.green, color.blue);
            end
            else
            begin
                $display("colour mismatch: hue %0d sat %0d int %0d", due.pix.hue_deg,
                         due.pix.saturation, due.pix.intensity);
                $display("  expected %0d/%0d/%0d got %0d/%0d/%0d",
                         due.colour.red, due.colour.green, due.colour.blue,
                         color.red, color.green, color.blue);
            end
        end
    endtask

    // sender
    always @(negedge clk)
    begin : sender
        pixel_offer_t offer;
        if (rst_n && (!push || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (pixel_backlog.size() > 0)
            begin
                offer    = pixel_backlog.pop_front();
                pixel    <= offer.pix;
                push     <= 1'b1;
                gap_left = offer.gap;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off twice to back the block up to full
    always @(negedge clk)
    begin
        if (rst_n && (!pop || out_taken))
        begin
            if (out_taken && (received == 40 || received == 450))
            begin
                hold_left = LONG_HOLD;
            end
            else if (out_taken)
            begin
                hold_left = draw_receiver_wait();
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        colour_due_t due;
        colour_due_t fresh;
        if (rst_n)
        begin
            in_taken  <= push && !full;
            out_taken <= pop && !empty;
            if (push && !full)
            begin
                fresh.pix    = pixel;
                fresh.colour = convert_pixel(pixel);
                colour_due.push_back(fresh);
                accepted++;
            end
            if (pop && !empty)
            begin
                received++;
                if (colour_due.size() == 0)
                begin
                    report_mismatch(fresh, 1'b1);
                end
                else
                begin
                    due = colour_due.pop_front();
                    if (color.red !== due.colour.red || color.green !== due.colour.green
                        || color.blue !== due.colour.blue)
                    begin
                        report_mismatch(due, 1'b0);
                    end
                end
            end
            if ((push && !full) || (pop && !empty))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
    end

    initial
    begin
        int unsigned hue;
        int unsigned gap;
        fill_hue_ratio();

        // sector edges, wrap of the hue, grey, black, levels above full scale
        queue_pixel(0, 256, 256, 0);
        queue_pixel(119, 256, 256, 0);
        queue_pixel(120, 256, 256, 0);
        queue_pixel(239, 256, 256, 3);
        queue_pixel(240, 256, 256, 0);
        queue_pixel(359, 256, 256, 0);
        queue_pixel(360, 256, 256, 17);
        queue_pixel(511, 256, 256, 0);
        queue_pixel(60, 256, 256, 0);
        queue_pixel(180, 256, 256, 1);
        queue_pixel(300, 256, 256, 0);
        queue_pixel(30, 0, 256, 0);
        queue_pixel(150, 0, 0, 0);
        queue_pixel(0, 256, 0, 5);
        queue_pixel(30, 128, 128, 0);
        queue_pixel(200, 511, 511, 0);
        queue_pixel(90, 0, 511, 0);
        queue_pixel(10, 511, 256, 0);
        queue_pixel(119, 511, 300, 2);
        queue_pixel(239, 511, 1, 0);
        queue_pixel(359, 1, 1, 0);
        queue_pixel(1, 300, 200, 0);
        queue_pixel(480, 257, 257, 0);
        queue_pixel(330, 511, 0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                hue = $urandom_range(0, 3) * 120 + (($urandom_range(0, 1) == 1) ? 119 : 0);
            end
            else
            begin
                hue = $urandom_range(0, 511);
            end
            case ((n / 50) % 4)
                1:       gap = $urandom_range(0, 17);
                2:       gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
                default: gap = 0;
            endcase
            queue_pixel(hue, draw_level(), draw_level(), gap);
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (received < total_items && stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        if (stall_cycles < STALL_LIMIT)
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        $display("covered %0d pixels over every hue sector, wrap and level extreme", accepted);
        $display("%0d colours checked under random stalls and back-pressure, %0d mismatches",
                 received, mismatches);
        if (stall_cycles >= STALL_LIMIT || colour_due.size() != 0 || mismatches != 0)
        begin
            $display("tb: failure");
        end
        else
        begin
            $display("tb: success");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hsi_pkg.sv
src/hsi_fifo.sv
src/hsi_front.sv
src/hsi_back.sv
src/hsi_to_rgb_converter_core.sv
bench/tb_hsi_to_rgb_converter_core.sv
